>>> design/stpr_pkg.sv
// ----------------------------------------------------------------------------
// stpr_pkg
// Shared types, constants and the half-step coil table of the stepper
// half-step position controller.
// ----------------------------------------------------------------------------
package stpr_pkg;

   // Width of the stored position and target (8 to 32).
   localparam int POSITION_WIDTH = 32;
   // Width of the position and amount fields on the ports.
   localparam int FIELD_WIDTH    = 32;
   // Width of a position plus a signed amount without overflow.
   localparam int SUM_WIDTH      = FIELD_WIDTH + 1;
   localparam int TIMER_WIDTH    = 16;
   localparam int COIL_WIDTH     = 4;
   localparam int OPCODE_WIDTH   = 3;
   localparam int PHASE_WIDTH    = 3;

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
   localparam logic [TIMER_WIDTH-1:0] STEP_INTERVAL_RESET = TIMER_WIDTH'(2000);

   // Signed limits of the position range, extended to the sum width.
   localparam logic signed [SUM_WIDTH-1:0] POS_MAX_EXT =
      {{(SUM_WIDTH-POSITION_WIDTH+1){1'b0}}, {(POSITION_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] POS_MIN_EXT =
      {{(SUM_WIDTH-POSITION_WIDTH+1){1'b1}}, {(POSITION_WIDTH-1){1'b0}}};

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_TICK     = 3'd0,
      OP_RUN_CW   = 3'd1,
      OP_RUN_CCW  = 3'd2,
      OP_MOVE_REL = 3'd3,
      OP_GO_ABS   = 3'd4,
      OP_STOP     = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_CW   = 2'd1,
      MODE_CCW  = 2'd2,
      MODE_SEEK = 2'd3
   } mode_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0]       opcode;
      logic signed [FIELD_WIDTH-1:0] amount;
   } item_type;

   // Coil drive for each position modulo 8; bit 0 is A0, then B0, A1, B1.
   function automatic logic [COIL_WIDTH-1:0] half_step(input logic [PHASE_WIDTH-1:0] phase);
      logic [COIL_WIDTH-1:0] coils;
      case (phase)
         3'd0:    coils = 4'h8;
         3'd1:    coils = 4'hC;
         3'd2:    coils = 4'h4;
         3'd3:    coils = 4'h6;
         3'd4:    coils = 4'h2;
         3'd5:    coils = 4'h3;
         3'd6:    coils = 4'h1;
         3'd7:    coils = 4'h9;
         default: coils = 4'h0;
      endcase
      return coils;
   endfunction

   // Clamp a wide signed value into the signed position range.
   function automatic logic signed [POSITION_WIDTH-1:0] saturate_pos(
      input logic signed [SUM_WIDTH-1:0] value);
      logic signed [POSITION_WIDTH-1:0] result;
      if (value > POS_MAX_EXT) begin
         result = POS_MAX_EXT[POSITION_WIDTH-1:0];
      end else if (value < POS_MIN_EXT) begin
         result = POS_MIN_EXT[POSITION_WIDTH-1:0];
      end else begin
         result = value[POSITION_WIDTH-1:0];
      end
      return result;
   endfunction

endpackage

>>> design/stpr_req_if.sv
// ----------------------------------------------------------------------------
// stpr_req_if
// Request channel: one tick or motion command per transaction.
// ----------------------------------------------------------------------------
interface stpr_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [stpr_pkg::OPCODE_WIDTH-1:0]         opcode;
   logic signed [stpr_pkg::FIELD_WIDTH-1:0]   amount;

   modport source (output valid, output opcode, output amount, input ready);
   modport sink   (input valid, input opcode, input amount, output ready);
endinterface

>>> design/stpr_rsp_if.sv
// ----------------------------------------------------------------------------
// stpr_rsp_if
// Response channel: coil drive and motion status after each request.
// ----------------------------------------------------------------------------
interface stpr_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [stpr_pkg::COIL_WIDTH-1:0]           coils;
   logic signed [stpr_pkg::FIELD_WIDTH-1:0]   position;
   logic                                      busy_res;
   logic                                      stepped;

   modport source (output valid, output coils, output position, output busy_res,
                   output stepped, input ready);
   modport sink   (input valid, input coils, input position, input busy_res,
                   input stepped, output ready);
endinterface

>>> design/stpr_input_stage.sv
// ----------------------------------------------------------------------------
// stpr_input_stage
// Input register for request transactions; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module stpr_input_stage (
   input  logic                clock,
   input  logic                reset,
   stpr_req_if.sink            req_bus,
   output logic                item_valid,
   output stpr_pkg::item_type  item,
   input  logic                item_take
);

   logic               valid_ff;
   logic               valid_in;
   stpr_pkg::item_type item_ff;
   stpr_pkg::item_type item_in;
   logic               load;

   assign req_bus.ready = !valid_ff || item_take;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in       = 1'b1;
         item_in.opcode = req_bus.opcode;
         item_in.amount = req_bus.amount;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

   // A held item must not change until the core takes it.
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid && !item_take |=> item_valid && $stable(item))
      else $error("stpr_input_stage: held item changed before it was taken");

   // The core only takes an item that is present.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      item_take |-> item_valid)
      else $error("stpr_input_stage: item taken while none held");

   // A newly loaded item is present in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> item_valid)
      else $error("stpr_input_stage: loaded item not held");

endmodule

>>> design/stpr_motion_core.sv
// ----------------------------------------------------------------------------
// stpr_motion_core
// Motion state, step timer and half-step update; result register.
// ----------------------------------------------------------------------------
module stpr_motion_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [stpr_pkg::TIMER_WIDTH-1:0]       csr_wr_data,
   input  logic                                   item_valid,
   input  stpr_pkg::item_type                     item,
   output logic                                   item_take,
   stpr_rsp_if.source                             rsp_bus
);

   localparam int P = stpr_pkg::POSITION_WIDTH;

   logic [stpr_pkg::TIMER_WIDTH-1:0] step_interval_ff;
   logic signed [P-1:0]              pos_ff;
   logic signed [P-1:0]              pos_in;
   logic signed [P-1:0]              tgt_ff;
   logic signed [P-1:0]              tgt_in;
   stpr_pkg::mode_type               mode_ff;
   stpr_pkg::mode_type               mode_in;
   logic [stpr_pkg::TIMER_WIDTH-1:0] timer_ff;
   logic [stpr_pkg::TIMER_WIDTH-1:0] timer_in;
   logic [stpr_pkg::COIL_WIDTH-1:0]  coil_ff;
   logic [stpr_pkg::COIL_WIDTH-1:0]  coil_in;
   logic                             stepped_in;

   logic [stpr_pkg::TIMER_WIDTH-1:0] timer_inc;
   logic signed [P-1:0]              step_pos;
   logic signed [P-1:0]              seek_tgt;
   logic signed [stpr_pkg::SUM_WIDTH-1:0] seek_raw;

   logic                                   rsp_valid_ff;
   logic [stpr_pkg::COIL_WIDTH-1:0]        rsp_coils_ff;
   logic signed [stpr_pkg::FIELD_WIDTH-1:0] rsp_position_ff;
   logic                                   rsp_busy_ff;
   logic                                   rsp_stepped_ff;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_interval_ff <= stpr_pkg::STEP_INTERVAL_RESET;
      end else if (csr_wr_en) begin
         step_interval_ff <= csr_wr_data;
      end
   end

   // Position after one half step in the current mode.
   always_comb begin
      case (mode_ff)
         stpr_pkg::MODE_CW:  step_pos = pos_ff + P'(1);
         stpr_pkg::MODE_CCW: step_pos = pos_ff - P'(1);
         stpr_pkg::MODE_SEEK: begin
            if (pos_ff < tgt_ff) begin
               step_pos = pos_ff + P'(1);
            end else if (pos_ff > tgt_ff) begin
               step_pos = pos_ff - P'(1);
            end else begin
               step_pos = pos_ff;
            end
         end
         default: step_pos = pos_ff;
      endcase
   end

   // The target of a relative move is the present position plus the amount.
   always_comb begin
      if (item.opcode == stpr_pkg::OP_MOVE_REL) begin
         seek_raw = stpr_pkg::SUM_WIDTH'(pos_ff) + stpr_pkg::SUM_WIDTH'(item.amount);
      end else begin
         seek_raw = stpr_pkg::SUM_WIDTH'(item.amount);
      end
      seek_tgt = stpr_pkg::saturate_pos(seek_raw);
   end

   assign timer_inc = (timer_ff == stpr_pkg::TIMER_MAX) ? timer_ff
                                                        : timer_ff + 1'b1;

   always_comb begin
      pos_in     = pos_ff;
      tgt_in     = tgt_ff;
      mode_in    = mode_ff;
      timer_in   = timer_ff;
      coil_in    = coil_ff;
      stepped_in = 1'b0;
      case (item.opcode)
         stpr_pkg::OP_TICK: begin
            if (mode_ff != stpr_pkg::MODE_IDLE) begin
               timer_in = timer_inc;
               if (timer_inc >= step_interval_ff) begin
                  stepped_in = 1'b1;
                  pos_in     = step_pos;
                  coil_in    = stpr_pkg::half_step(step_pos[stpr_pkg::PHASE_WIDTH-1:0]);
                  timer_in   = '0;
                  if (mode_ff == stpr_pkg::MODE_SEEK && step_pos == tgt_ff) begin
                     mode_in = stpr_pkg::MODE_IDLE;
                  end
               end
            end
         end
         stpr_pkg::OP_RUN_CW: begin
            mode_in  = stpr_pkg::MODE_CW;
            timer_in = '0;
         end
         stpr_pkg::OP_RUN_CCW: begin
            mode_in  = stpr_pkg::MODE_CCW;
            timer_in = '0;
         end
         stpr_pkg::OP_MOVE_REL, stpr_pkg::OP_GO_ABS: begin
            tgt_in   = seek_tgt;
            mode_in  = (seek_tgt == pos_ff) ? stpr_pkg::MODE_IDLE : stpr_pkg::MODE_SEEK;
            timer_in = '0;
         end
         stpr_pkg::OP_STOP: begin
            mode_in  = stpr_pkg::MODE_IDLE;
            timer_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         tgt_ff   <= '0;
         mode_ff  <= stpr_pkg::MODE_IDLE;
         timer_ff <= '0;
         coil_ff  <= '0;
      end else if (item_take) begin
         pos_ff   <= pos_in;
         tgt_ff   <= tgt_in;
         mode_ff  <= mode_in;
         timer_ff <= timer_in;
         coil_ff  <= coil_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_coils_ff    <= coil_in;
         rsp_position_ff <= stpr_pkg::FIELD_WIDTH'(pos_in);
         rsp_busy_ff     <= (mode_in != stpr_pkg::MODE_IDLE);
         rsp_stepped_ff  <= stepped_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.coils    = rsp_coils_ff;
   assign rsp_bus.position = rsp_position_ff;
   assign rsp_bus.busy_res = rsp_busy_ff;
   assign rsp_bus.stepped  = rsp_stepped_ff;

   // After a step the coils always match the reported position.
   a_coils_follow_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stepped_ff |->
         rsp_coils_ff == stpr_pkg::half_step(rsp_position_ff[stpr_pkg::PHASE_WIDTH-1:0]))
      else $error("stpr_motion_core: coil pattern does not match position after a step");

   // The timer never runs while the motor is idle.
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      mode_ff == stpr_pkg::MODE_IDLE |-> timer_ff == '0)
      else $error("stpr_motion_core: timer non-zero while idle");

   // A seek ends as soon as the target is reached.
   a_seek_open: assert property (@(posedge clock) disable iff (reset)
      mode_ff == stpr_pkg::MODE_SEEK |-> pos_ff != tgt_ff)
      else $error("stpr_motion_core: seeking while already at target");

   // A waiting response is not overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !item_take)
      else $error("stpr_motion_core: stalled response overwritten");

endmodule

>>> design/stepper_half_step_position_controller.sv
// ----------------------------------------------------------------------------
// stepper_half_step_position_controller
// Half-step sequencer for a four-coil unipolar stepper with position control.
// ----------------------------------------------------------------------------
// Each transaction on req_bus is either a microsecond tick or a command
// (run clockwise, run counter-clockwise, move relative, go absolute, stop).
// Every accepted request yields exactly one transaction on rsp_bus carrying
// the coil drive, the position, a busy flag and whether a step was taken.
// csr_wr_en and csr_wr_data set the step interval in ticks; write it only
// while no request is outstanding.
// A request accepted on req_bus is registered in the input register, then
// processed by the motion core into the response register, which drives
// rsp_bus. One request is accepted in every cycle while the receiver does
// not stall; the state update between the input register and the response
// register is combinational.
// When the receiver stalls, the response is held and the input register
// keeps the next request; req_bus.ready falls only when both are full.
// Reset clears the position, target and timer, makes the motor idle with
// all coils off, and restores the step interval to 2000 ticks.
// ----------------------------------------------------------------------------
module stepper_half_step_position_controller (
   input  logic                             clock,
   input  logic                             reset,
   stpr_req_if.sink                         req_bus,
   stpr_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [stpr_pkg::TIMER_WIDTH-1:0] csr_wr_data
);

   logic               item_valid;
   logic               item_take;
   stpr_pkg::item_type item;

   stpr_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   stpr_motion_core u_motion_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take),
      .rsp_bus     (rsp_bus)
   );

endmodule

>>> tb/stepper_half_step_position_controller_test.sv
// ----------------------------------------------------------------------------
// stepper_half_step_position_controller_test
// Self-checking testbench for the stepper half-step position controller.
// ----------------------------------------------------------------------------
// Ticks and motion commands are offered on the request channel while a
// tracking model of the motor predicts the coil drive, position, busy flag
// and step flag for every accepted request. Each response is compared with
// the oldest prediction. Directed sequences cover idle commands, the zero
// and largest step intervals, target saturation and a change of interval
// in mid-motion; random phases then mix ticks with commands under random
// stalls on both channels, a long receiver hold-off and a steady stream.
// ----------------------------------------------------------------------------
module stepper_half_step_position_controller_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int HOLD_CYCLES      = 150;
   localparam int SETTLE_CYCLES    = 4;
   localparam int RANDOM_PHASES    = 6;
   localparam int PHASE_ITEMS      = 240;
   localparam int LONG_RUN_TICKS   = 40;

   // Opcodes outside the defined set; the block must leave its state alone.
   localparam logic [stpr_pkg::OPCODE_WIDTH-1:0] OP_SPARE_LOW  = 3'd6;
   localparam logic [stpr_pkg::OPCODE_WIDTH-1:0] OP_SPARE_HIGH = 3'd7;

   localparam longint POS_HI = (longint'(1) <<< (stpr_pkg::POSITION_WIDTH - 1)) - 1;
   localparam longint POS_LO = -POS_HI - 1;

   localparam logic signed [stpr_pkg::FIELD_WIDTH-1:0] AMOUNT_MAX =
      {1'b0, {(stpr_pkg::FIELD_WIDTH-1){1'b1}}};
   localparam logic signed [stpr_pkg::FIELD_WIDTH-1:0] AMOUNT_MIN =
      {1'b1, {(stpr_pkg::FIELD_WIDTH-1){1'b0}}};

   localparam logic [stpr_pkg::COIL_WIDTH-1:0] COIL_SEQUENCE [8] =
      '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

   typedef struct {
      logic [stpr_pkg::COIL_WIDTH-1:0]         coils;
      logic signed [stpr_pkg::FIELD_WIDTH-1:0] position;
      logic                                    busy_res;
      logic                                    stepped;
   } drive_state_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_wr_en;
   logic [stpr_pkg::TIMER_WIDTH-1:0] csr_wr_data;

   stpr_req_if req_bus ();
   stpr_rsp_if rsp_bus ();

   stepper_half_step_position_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Tracking model of the motor.
   longint                           track_position;
   longint                           track_target;
   stpr_pkg::mode_type               track_mode;
   int unsigned                      track_timer;
   logic [stpr_pkg::COIL_WIDTH-1:0]  track_coils;
   logic [stpr_pkg::TIMER_WIDTH-1:0] track_interval;

   drive_state_type pending_drive [$];

   bit tx_gaps       = 1'b1;
   bit rx_stalls     = 1'b1;
   bit hold_request  = 1'b0;
   int failures      = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int steps_seen    = 0;

   function automatic longint clamp_position(input longint value);
      longint result;
      result = value;
      if (value > POS_HI) begin
         result = POS_HI;
      end else if (value < POS_LO) begin
         result = POS_LO;
      end
      return result;
   endfunction

   function automatic void start_seek(input longint goal);
      track_target = clamp_position(goal);
      track_mode   = (track_target == track_position) ? stpr_pkg::MODE_IDLE
                                                      : stpr_pkg::MODE_SEEK;
      track_timer  = 0;
   endfunction

   function automatic void take_half_step();
      case (track_mode)
         stpr_pkg::MODE_CW: begin
            track_position = (track_position == POS_HI) ? POS_LO : track_position + 1;
         end
         stpr_pkg::MODE_CCW: begin
            track_position = (track_position == POS_LO) ? POS_HI : track_position - 1;
         end
         default: begin
            if (track_position < track_target) begin
               track_position = track_position + 1;
            end else if (track_position > track_target) begin
               track_position = track_position - 1;
            end
            if (track_position == track_target) begin
               track_mode = stpr_pkg::MODE_IDLE;
            end
         end
      endcase
      track_coils = COIL_SEQUENCE[track_position[2:0]];
      track_timer = 0;
   endfunction

   // Applies one request to the tracking model and returns the drive state
   // that the block should report for it.
   function automatic drive_state_type advance_motor(
      input logic [stpr_pkg::OPCODE_WIDTH-1:0]       op,
      input logic signed [stpr_pkg::FIELD_WIDTH-1:0] amt);
      drive_state_type result;
      logic            stepped;
      stepped = 1'b0;
      case (op)
         stpr_pkg::OP_TICK: begin
            if (track_mode != stpr_pkg::MODE_IDLE) begin
               if (track_timer < stpr_pkg::TIMER_MAX) begin
                  track_timer++;
               end
               if (track_timer >= track_interval) begin
                  take_half_step();
                  stepped = 1'b1;
               end
            end
         end
         stpr_pkg::OP_RUN_CW: begin
            track_mode  = stpr_pkg::MODE_CW;
            track_timer = 0;
         end
         stpr_pkg::OP_RUN_CCW: begin
            track_mode  = stpr_pkg::MODE_CCW;
            track_timer = 0;
         end
         stpr_pkg::OP_MOVE_REL: start_seek(track_position + longint'(amt));
         stpr_pkg::OP_GO_ABS:   start_seek(longint'(amt));
         stpr_pkg::OP_STOP: begin
            track_mode  = stpr_pkg::MODE_IDLE;
            track_timer = 0;
         end
         default: ;
      endcase
      result.coils    = track_coils;
      result.position = track_position[stpr_pkg::FIELD_WIDTH-1:0];
      result.busy_res = (track_mode != stpr_pkg::MODE_IDLE);
      result.stepped  = stepped;
      return result;
   endfunction

   function automatic void reset_motor_track();
      track_position = 0;
      track_target   = 0;
      track_mode     = stpr_pkg::MODE_IDLE;
      track_timer    = 0;
      track_coils    = '0;
      track_interval = stpr_pkg::STEP_INTERVAL_RESET;
   endfunction

   // Offers one request and records its prediction once it is accepted.
   // The valid line is left high afterwards so that back-to-back
   // transactions need no second assignment in the same time step.
   task automatic send_item(input logic [stpr_pkg::OPCODE_WIDTH-1:0] op,
                            input logic signed [stpr_pkg::FIELD_WIDTH-1:0] amt);
      int gap;
      gap = 0;
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.amount <= amt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_drive.push_back(advance_motor(op, amt));
      if (op <= stpr_pkg::OP_STOP) begin
         items_sent++;
      end
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(stpr_pkg::OP_TICK, $urandom);
   endtask

   // Stops offering and waits for every outstanding response.
   task automatic settle_pipeline();
      req_bus.valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(input logic [stpr_pkg::TIMER_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      track_interval = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_idle_commands();
      send_item(stpr_pkg::OP_TICK, $urandom);
      send_item(stpr_pkg::OP_STOP, $urandom);
      send_item(OP_SPARE_LOW, $urandom);
      send_item(OP_SPARE_HIGH, $urandom);
      settle_pipeline();
   endtask

   // An interval of zero behaves like one: every tick takes a step.
   task automatic test_zero_interval();
      write_interval('0);
      send_item(stpr_pkg::OP_RUN_CW, $urandom);
      send_ticks(1);
      send_item(stpr_pkg::OP_RUN_CCW, $urandom);
      send_ticks(2);
      settle_pipeline();
   endtask

   task automatic test_seek_targets();
      write_interval(16'd1);
      // From a negative position the target clamps to the lowest value.
      send_item(stpr_pkg::OP_MOVE_REL, AMOUNT_MIN);
      send_ticks(1);
      send_item(stpr_pkg::OP_MOVE_REL, '0);
      send_item(stpr_pkg::OP_GO_ABS, track_position[stpr_pkg::FIELD_WIDTH-1:0]);
      send_item(stpr_pkg::OP_MOVE_REL, 32'sd3);
      send_ticks(4);
      send_item(stpr_pkg::OP_MOVE_REL, AMOUNT_MAX);
      send_ticks(1);
      send_item(stpr_pkg::OP_GO_ABS, AMOUNT_MIN);
      send_ticks(1);
      send_item(stpr_pkg::OP_STOP, $urandom);
      settle_pipeline();
   endtask

   // The timer holds its count across a quiet channel, so a shorter interval
   // written in mid-motion must cause a step on the very next tick.
   task automatic test_interval_change();
      write_interval(16'd50);
      send_item(stpr_pkg::OP_RUN_CW, $urandom);
      send_ticks(30);
      settle_pipeline();
      write_interval(16'd10);
      send_ticks(3);
      send_item(stpr_pkg::OP_STOP, $urandom);
      settle_pipeline();
   endtask

   // With the largest interval a short burst of ticks keeps the motor busy
   // without taking a step.
   task automatic test_longest_interval();
      write_interval(stpr_pkg::TIMER_MAX);
      send_item(stpr_pkg::OP_RUN_CCW, $urandom);
      send_ticks(LONG_RUN_TICKS);
      send_item(stpr_pkg::OP_STOP, $urandom);
      settle_pipeline();
   endtask

   // Mostly ticks, so that moves run to their targets; commands carry small
   // offsets around the current position, with full-range and extreme
   // amounts mixed in.
   task automatic send_random_items(input int count);
      int                                      sent;
      int                                      roll;
      int                                      pick;
      logic [stpr_pkg::OPCODE_WIDTH-1:0]       op;
      logic signed [stpr_pkg::FIELD_WIDTH-1:0] amt;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, 9);
         amt  = $urandom;
         if (roll < 78) begin
            op = stpr_pkg::OP_TICK;
         end else if (roll < 80) begin
            op = $urandom_range(0, 1) ? OP_SPARE_HIGH : OP_SPARE_LOW;
         end else begin
            op = stpr_pkg::OPCODE_WIDTH'($urandom_range(stpr_pkg::OP_RUN_CW,
                                                        stpr_pkg::OP_STOP));
         end
         if (op == stpr_pkg::OP_MOVE_REL && pick < 7) begin
            amt = int'($urandom_range(0, 40)) - 20;
         end else if (op == stpr_pkg::OP_GO_ABS && pick < 7) begin
            amt = track_position[stpr_pkg::FIELD_WIDTH-1:0] + int'($urandom_range(0, 40)) - 20;
         end else if (pick == 9) begin
            amt = $urandom_range(0, 1) ? AMOUNT_MAX : AMOUNT_MIN;
         end
         send_item(op, amt);
         if (op <= stpr_pkg::OP_STOP) begin
            sent++;
         end
      end
   endtask

   task automatic test_random_phases();
      int phase;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 3)
            0:       write_interval(stpr_pkg::TIMER_WIDTH'($urandom_range(1, 2)));
            1:       write_interval(stpr_pkg::TIMER_WIDTH'($urandom_range(3, 6)));
            default: write_interval(stpr_pkg::TIMER_WIDTH'($urandom_range(7, 40)));
         endcase
         send_random_items(PHASE_ITEMS);
         settle_pipeline();
      end
   endtask

   // The receiver holds off while requests keep coming, so the block fills
   // up and must stall its input; then the sender pauses until it drains.
   task automatic test_backpressure();
      write_interval(16'd2);
      tx_gaps      = 1'b0;
      hold_request = 1'b1;
      send_item(stpr_pkg::OP_RUN_CW, $urandom);
      send_random_items(40);
      settle_pipeline();
      send_random_items(20);
      tx_gaps = 1'b1;
      settle_pipeline();
   endtask

   task automatic test_steady_stream();
      tx_gaps   = 1'b0;
      rx_stalls = 1'b0;
      write_interval(16'd1);
      send_random_items(200);
      settle_pipeline();
   endtask

   task automatic check_response();
      drive_state_type want;
      if (pending_drive.size() == 0) begin
         $error("response with no request outstanding: coils %h position %0d",
                rsp_bus.coils, rsp_bus.position);
         failures++;
      end else begin
         want = pending_drive.pop_front();
         if (rsp_bus.coils !== want.coils) begin
            $error("coils: expected %h, actual %h", want.coils, rsp_bus.coils);
            failures++;
         end
         if (rsp_bus.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, rsp_bus.position);
            failures++;
         end
         if (rsp_bus.busy_res !== want.busy_res) begin
            $error("busy_res: expected %b, actual %b", want.busy_res, rsp_bus.busy_res);
            failures++;
         end
         if (rsp_bus.stepped !== want.stepped) begin
            $error("stepped: expected %b, actual %b", want.stepped, rsp_bus.stepped);
            failures++;
         end
         results_seen++;
         if (want.stepped) begin
            steps_seen++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         check_response();
      end
   end

   // Receiver: random stall bursts, and one long hold-off on request.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Ends the run if neither channel moves a transaction for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("stepper_half_step_position_controller verification failed");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.opcode <= stpr_pkg::OP_TICK;
      req_bus.amount <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      reset_motor_track();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_idle_commands();
      test_zero_interval();
      test_seek_targets();
      test_interval_change();
      test_longest_interval();
      test_random_phases();
      test_backpressure();
      test_steady_stream();

      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      $display("Sent %0d ticks and commands over step intervals 0, 1, 65535 and random,",
               items_sent);
      $display("checked %0d responses and saw %0d half steps, %0d mismatches.",
               results_seen, steps_seen, failures);
      if (failures == 0) begin
         $display("stepper_half_step_position_controller verification clean");
      end else begin
         $display("stepper_half_step_position_controller verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
design/stpr_pkg.sv
design/stpr_req_if.sv
design/stpr_rsp_if.sv
design/stpr_input_stage.sv
design/stpr_motion_core.sv
design/stepper_half_step_position_controller.sv
tb/stepper_half_step_position_controller_test.sv
